FILE: design/bitstream_exp_golomb_reader_unit_macros.svh
// assertion macros for the exp-golomb bitstream reader
`ifndef BITSTREAM_EXP_GOLOMB_READER_UNIT_MACROS_SVH
`define BITSTREAM_EXP_GOLOMB_READER_UNIT_MACROS_SVH

// same-cycle implication
`define EGBR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("egbr assertion failed");

// next-cycle implication
`define EGBR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("egbr assertion failed");

`endif

FILE: design/egbr_pkg.sv
// shared types and constants for the exp-golomb bitstream reader
package egbr_pkg;

   localparam int DEFAULT_BUFFER_BYTES = 4096;

   localparam int CMD_W    = 3;
   localparam int COUNT_W  = 7;
   localparam int WVAL_W   = 32;
   localparam int ADDR_W   = 12;
   localparam int DATA_W   = 8;
   localparam int RESULT_W = 64;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 16;
   localparam int PREF_W   = 6;
   localparam int TAKE_W   = 4;
   localparam int ZEROS_W  = 5;

   localparam int BYTE_BITS     = 8;
   localparam int MAX_READ_BITS = 64;
   localparam int MAX_PUT_BITS  = 32;
   localparam int MAX_UE_ZEROS  = 31;
   localparam int UE_SCAN_BITS  = MAX_UE_ZEROS + 2;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_DATA     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_PREFIX_LONG = 2'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 3'd0,
      CMD_FETCH  = 3'd1,
      CMD_READ   = 3'd2,
      CMD_PEEK   = 3'd3,
      CMD_UE     = 3'd4,
      CMD_SE     = 3'd5,
      CMD_PUT    = 3'd6,
      CMD_REWIND = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_UE_SUM,
      ST_SE_MAP,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      MD_BYTE,
      MD_BITS,
      MD_PREFIX,
      MD_PUT
   } mode_type;

   typedef struct packed {
      mode_type              mode;
      logic [POS_W-1:0]      pos;
      logic [POS_W-1:0]      lim;
      logic [COUNT_W-1:0]    rem;
      logic [PREF_W-1:0]     pref_cnt;
      logic [DATA_W-1:0]     data;
      logic [RESULT_W-1:0]   acc;
      logic [WVAL_W-1:0]     wval;
   } chunk_req_type;

   typedef struct packed {
      logic [TAKE_W-1:0]     take;
      logic [TAKE_W-1:0]     consumed;
      logic                  found;
      logic [DATA_W-1:0]     new_byte;
      logic [RESULT_W-1:0]   acc;
   } chunk_rsp_type;

endpackage

FILE: design/egbr_if.sv
// request and response channel interfaces of the exp-golomb bitstream reader
interface egbr_req_if;
   import egbr_pkg::*;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [COUNT_W-1:0]  bit_count;
   logic [WVAL_W-1:0]   write_value;
   logic [ADDR_W-1:0]   byte_address;
   logic [DATA_W-1:0]   byte_data;

   modport source (output valid, command, bit_count, write_value, byte_address, byte_data,
                   input ready);
   modport sink (input valid, command, bit_count, write_value, byte_address, byte_data,
                 output ready);
endinterface

interface egbr_rsp_if;
   import egbr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [RESULT_W-1:0]  result_value;
   logic [STATUS_W-1:0]  status;
   logic [POS_W-1:0]     bit_position;

   modport source (output valid, result_value, status, bit_position, input ready);
   modport sink (input valid, result_value, status, bit_position, output ready);
endinterface

FILE: design/egbr_ram.sv
// generic single-port-write ram with registered read
module egbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;
endmodule

FILE: design/egbr_chunk.sv
// shared byte window unit: extracts, scans or merges the bits of one byte
module egbr_chunk (
   input  egbr_pkg::chunk_req_type chunk_req,
   output egbr_pkg::chunk_rsp_type chunk_rsp
);
   import egbr_pkg::*;

   logic [2:0]          bit_in_byte;
   logic [TAKE_W-1:0]   room;
   logic [POS_W-1:0]    span;
   logic [TAKE_W-1:0]   span_cap;
   logic [COUNT_W-1:0]  need;
   logic [TAKE_W-1:0]   need_cap;
   logic [TAKE_W-1:0]   take;
   logic [TAKE_W-1:0]   shift_r;
   logic [DATA_W-1:0]   low_mask;
   logic [DATA_W-1:0]   top_mask;
   logic [DATA_W-1:0]   field;
   logic [DATA_W-1:0]   window;
   logic [TAKE_W-1:0]   lead_zeros;
   logic                found;
   logic [COUNT_W-1:0]  put_shift;
   logic [DATA_W-1:0]   put_bits;
   logic [DATA_W-1:0]   put_mask;

   always_comb begin
      bit_in_byte = chunk_req.pos[2:0];
      room        = TAKE_W'(BYTE_BITS) - {1'b0, bit_in_byte};
      span        = chunk_req.lim - chunk_req.pos;
      span_cap    = (span >= POS_W'(BYTE_BITS)) ? TAKE_W'(BYTE_BITS) : span[TAKE_W-1:0];
      need        = (chunk_req.mode == MD_PREFIX)
                    ? (COUNT_W'(UE_SCAN_BITS) - {1'b0, chunk_req.pref_cnt})
                    : chunk_req.rem;
      need_cap    = (need >= COUNT_W'(BYTE_BITS)) ? TAKE_W'(BYTE_BITS) : need[TAKE_W-1:0];
      take        = room;
      if (span_cap < take) begin
         take = span_cap;
      end
      if (need_cap < take) begin
         take = need_cap;
      end
      shift_r  = room - take;
      low_mask = ~(8'hFF << take);
      top_mask = ~(8'hFF >> take);
      field    = (chunk_req.data >> shift_r) & low_mask;

      window     = (chunk_req.data << bit_in_byte) & top_mask;
      lead_zeros = TAKE_W'(BYTE_BITS);
      for (int i = 0; i < BYTE_BITS; i++) begin
         if (window[i]) begin
            lead_zeros = TAKE_W'(BYTE_BITS - 1 - i);
         end
      end
      found = (lead_zeros < take);

      put_shift = chunk_req.rem - COUNT_W'(take);
      put_bits  = DATA_W'(chunk_req.wval >> put_shift) & low_mask;
      put_mask  = low_mask << shift_r;

      chunk_rsp.take     = take;
      chunk_rsp.found    = found;
      chunk_rsp.consumed = found ? (lead_zeros + TAKE_W'(1)) : take;
      chunk_rsp.acc      = (chunk_req.acc << take) | RESULT_W'(field);
      chunk_rsp.new_byte = (chunk_req.data & ~put_mask) | ((put_bits << shift_r) & put_mask);
   end
endmodule

FILE: design/bitstream_exp_golomb_reader_unit.sv
// top level of the command-driven exp-golomb bitstream reader and writer
//
// one command enters on req_if per transaction and gives exactly one response
// transaction on rsp_if. commands: load byte, fetch byte, read or peek up to 64
// bits, decode unsigned or signed exp-golomb, put up to 32 bits, rewind.
// csr_write_enable/csr_write_data set the stream length in bits; write it while idle.
// each touched byte takes one sequencer pass: a ram read in the scan state, then
// the shared byte window unit in the apply state. load and rewind go straight to
// the response state; ue/se first scan the prefix bytes, then sum the code, and se
// maps it to a signed value. the registered ram read forces the two steps per byte.
// req_if.ready is high only while the sequencer is idle, one command at a time.
// the response sits in an output register; a stalled receiver holds it, and the
// next command is still accepted and waits in its last state for the slot.
// reset (synchronous) clears the bit offset, the stream length and the
// response valid; the byte store is not cleared and must be written first.
module bitstream_exp_golomb_reader_unit #(
   parameter int BUFFER_BYTES = egbr_pkg::DEFAULT_BUFFER_BYTES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [egbr_pkg::POS_W-1:0] csr_write_data,
   egbr_req_if.sink                   req_if,
   egbr_rsp_if.source                 rsp_if
);
   import egbr_pkg::*;

   localparam int          AW       = $clog2(BUFFER_BYTES);
   localparam logic [31:0] CAP_BITS = 32'(BUFFER_BYTES * BYTE_BITS);

   state_type              state_ff, state_in;
   mode_type               mode_ff, mode_in;
   cmd_type                cmd_ff, cmd_in;
   logic [POS_W-1:0]       length_ff, length_in;
   logic [POS_W-1:0]       off_ff, off_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [COUNT_W-1:0]     rem_ff, rem_in;
   logic [PREF_W-1:0]      pref_cnt_ff, pref_cnt_in;
   logic [ZEROS_W-1:0]     zeros_ff, zeros_in;
   logic                   found_ff, found_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [RESULT_W-1:0]    acc_ff, acc_in;
   logic [WVAL_W-1:0]      wval_ff, wval_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RESULT_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]       rsp_pos_ff, rsp_pos_in;

   logic                   req_accept;
   cmd_type                req_cmd;
   logic [31:0]            req_addr_wide;
   logic                   req_addr_ok;
   logic [31:0]            addr_wide;
   logic [31:0]            pos_idx_wide;
   logic [POS_W-1:0]       lim;
   logic                   at_end;
   logic                   bits_stop;
   logic                   prefix_stop;
   logic                   put_stop;
   logic                   issue;
   logic                   slot_free;
   logic                   is_ue_cmd;
   logic [WVAL_W-1:0]      ue_value;
   logic [RESULT_W-1:0]    half_value;

   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;
   logic [DATA_W-1:0]      ram_wdata;
   logic                   ram_re;
   logic [AW-1:0]          ram_raddr;
   logic [DATA_W-1:0]      ram_rdata;

   chunk_req_type          chunk_req;
   chunk_rsp_type          chunk_rsp;

   egbr_ram #(
      .WIDTH (DATA_W),
      .DEPTH (BUFFER_BYTES)
   ) u_store (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (ram_waddr),
      .write_data    (ram_wdata),
      .read_enable   (ram_re),
      .read_address  (ram_raddr),
      .read_data     (ram_rdata)
   );

   always_comb begin
      chunk_req.mode     = mode_ff;
      chunk_req.pos      = pos_ff;
      chunk_req.lim      = lim;
      chunk_req.rem      = rem_ff;
      chunk_req.pref_cnt = pref_cnt_ff;
      chunk_req.data     = ram_rdata;
      chunk_req.acc      = acc_ff;
      chunk_req.wval     = wval_ff;
   end

   egbr_chunk u_chunk (
      .chunk_req (chunk_req),
      .chunk_rsp (chunk_rsp)
   );

   assign req_accept    = req_if.valid && req_if.ready;
   assign req_cmd       = cmd_type'(req_if.command);
   assign req_addr_wide = 32'(req_if.byte_address);
   assign req_addr_ok   = req_addr_wide < 32'(BUFFER_BYTES);
   assign addr_wide     = 32'(addr_ff);
   assign pos_idx_wide  = 32'(pos_ff[POS_W-1:3]);
   assign lim           = (32'(length_ff) < CAP_BITS) ? length_ff : CAP_BITS[POS_W-1:0];
   assign at_end        = pos_ff >= lim;
   assign bits_stop     = (rem_ff == '0) || at_end;
   assign prefix_stop   = found_ff || (pref_cnt_ff == PREF_W'(UE_SCAN_BITS)) || at_end;
   assign put_stop      = (rem_ff == '0) || at_end;
   assign slot_free     = !rsp_valid_ff || rsp_if.ready;
   assign is_ue_cmd     = (cmd_ff == CMD_UE) || (cmd_ff == CMD_SE);
   assign ue_value      = ((WVAL_W'(1) << zeros_ff) | acc_ff[WVAL_W-1:0]) - WVAL_W'(1);
   assign half_value    = RESULT_W'(acc_ff[WVAL_W-1:1]);

   always_comb begin
      issue = 1'b0;
      if (state_ff == ST_SCAN) begin
         unique case (mode_ff)
            MD_BYTE:   issue = 1'b1;
            MD_BITS:   issue = !bits_stop;
            MD_PREFIX: issue = !prefix_stop;
            MD_PUT:    issue = !put_stop;
            default:   issue = 1'b0;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_cmd)
                  CMD_LOAD, CMD_REWIND: state_in = ST_RESP;
                  CMD_FETCH:            state_in = req_addr_ok ? ST_SCAN : ST_RESP;
                  default:              state_in = ST_SCAN;
               endcase
            end
         end
         ST_SCAN: begin
            if (issue) begin
               state_in = ST_APPLY;
            end else begin
               unique case (mode_ff)
                  MD_BITS: state_in = is_ue_cmd ? ST_UE_SUM : ST_RESP;
                  MD_PREFIX: begin
                     if ((pref_cnt_ff == '0) || (pref_cnt_ff == PREF_W'(UE_SCAN_BITS))) begin
                        state_in = ST_RESP;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_APPLY:  state_in = (mode_ff == MD_BYTE) ? ST_RESP : ST_SCAN;
         ST_UE_SUM: state_in = (cmd_ff == CMD_SE) ? ST_SE_MAP : ST_RESP;
         ST_SE_MAP: state_in = ST_RESP;
         ST_RESP:   state_in = slot_free ? ST_IDLE : ST_RESP;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_if.ready = (state_ff == ST_IDLE);
      ram_re       = issue;
      ram_raddr    = (mode_ff == MD_BYTE) ? addr_wide[AW-1:0] : pos_idx_wide[AW-1:0];
      ram_we       = 1'b0;
      ram_waddr    = pos_idx_wide[AW-1:0];
      ram_wdata    = chunk_rsp.new_byte;
      if ((state_ff == ST_IDLE) && req_accept && (req_cmd == CMD_LOAD) && req_addr_ok) begin
         ram_we    = 1'b1;
         ram_waddr = req_addr_wide[AW-1:0];
         ram_wdata = req_if.byte_data;
      end else if ((state_ff == ST_APPLY) && (mode_ff == MD_PUT)) begin
         ram_we = 1'b1;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.result_value = rsp_value_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.bit_position = rsp_pos_ff;

   // datapath
   always_comb begin
      mode_in       = mode_ff;
      cmd_in        = cmd_ff;
      length_in     = csr_write_enable ? csr_write_data : length_ff;
      off_in        = off_ff;
      pos_in        = pos_ff;
      rem_in        = rem_ff;
      pref_cnt_in   = pref_cnt_ff;
      zeros_in      = zeros_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      acc_in        = acc_ff;
      wval_in       = wval_ff;
      addr_in       = addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in      = req_cmd;
               wval_in     = req_if.write_value;
               addr_in     = req_if.byte_address;
               pos_in      = (req_cmd == CMD_REWIND) ? '0 : off_ff;
               acc_in      = '0;
               pref_cnt_in = '0;
               found_in    = 1'b0;
               status_in   = STATUS_OK;
               rem_in      = req_if.bit_count;
               if (((req_cmd == CMD_LOAD) || (req_cmd == CMD_FETCH)) && !req_addr_ok) begin
                  status_in = STATUS_NO_DATA;
               end
               unique case (req_cmd)
                  CMD_READ, CMD_PEEK: begin
                     mode_in = MD_BITS;
                     if (req_if.bit_count > COUNT_W'(MAX_READ_BITS)) begin
                        rem_in = COUNT_W'(MAX_READ_BITS);
                     end
                  end
                  CMD_UE, CMD_SE: mode_in = MD_PREFIX;
                  CMD_PUT: begin
                     mode_in = MD_PUT;
                     if (req_if.bit_count > COUNT_W'(MAX_PUT_BITS)) begin
                        rem_in = COUNT_W'(MAX_PUT_BITS);
                     end
                  end
                  default: mode_in = MD_BYTE;
               endcase
            end
         end
         ST_SCAN: begin
            if (!issue) begin
               unique case (mode_ff)
                  MD_BITS: begin
                     if (rem_ff != '0) begin
                        acc_in    = '0;
                        status_in = STATUS_NO_DATA;
                     end
                  end
                  MD_PREFIX: begin
                     if (pref_cnt_ff == '0) begin
                        status_in = STATUS_NO_DATA;
                     end else if (pref_cnt_ff == PREF_W'(UE_SCAN_BITS)) begin
                        status_in = STATUS_PREFIX_LONG;
                     end else begin
                        if (!found_ff) begin
                           status_in = STATUS_NO_DATA;
                        end
                        mode_in  = MD_BITS;
                        rem_in   = COUNT_W'(pref_cnt_ff - PREF_W'(1));
                        zeros_in = ZEROS_W'(pref_cnt_ff - PREF_W'(1));
                        acc_in   = '0;
                     end
                  end
                  MD_PUT: begin
                     if (rem_ff != '0) begin
                        status_in = STATUS_NO_DATA;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_APPLY: begin
            unique case (mode_ff)
               MD_BYTE: acc_in = RESULT_W'(ram_rdata);
               MD_PREFIX: begin
                  pos_in      = pos_ff + POS_W'(chunk_rsp.consumed);
                  pref_cnt_in = pref_cnt_ff + PREF_W'(chunk_rsp.consumed);
                  found_in    = chunk_rsp.found;
               end
               MD_BITS: begin
                  acc_in = chunk_rsp.acc;
                  pos_in = pos_ff + POS_W'(chunk_rsp.take);
                  rem_in = rem_ff - COUNT_W'(chunk_rsp.take);
               end
               default: begin
                  pos_in = pos_ff + POS_W'(chunk_rsp.take);
                  rem_in = rem_ff - COUNT_W'(chunk_rsp.take);
               end
            endcase
         end
         ST_UE_SUM: acc_in = RESULT_W'(ue_value);
         ST_SE_MAP: begin
            if (acc_ff[0]) begin
               acc_in = half_value + RESULT_W'(1);
            end else begin
               acc_in = RESULT_W'(0) - half_value;
            end
         end
         ST_RESP: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = acc_ff;
               rsp_status_in = status_ff;
               off_in        = (cmd_ff == CMD_PEEK) ? off_ff : pos_ff;
               rsp_pos_in    = (cmd_ff == CMD_PEEK) ? off_ff : pos_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         length_ff    <= '0;
         off_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         off_ff       <= off_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      cmd_ff        <= cmd_in;
      pos_ff        <= pos_in;
      rem_ff        <= rem_in;
      pref_cnt_ff   <= pref_cnt_in;
      zeros_ff      <= zeros_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      acc_ff        <= acc_in;
      wval_ff       <= wval_in;
      addr_ff       <= addr_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
   end
endmodule

FILE: design/egbr_checker.sv
// port-level assertion checker for the exp-golomb bitstream reader, with its bind
`include "bitstream_exp_golomb_reader_unit_macros.svh"

module egbr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [egbr_pkg::RESULT_W-1:0] rsp_result_value,
   input logic [egbr_pkg::STATUS_W-1:0] rsp_status,
   input logic [egbr_pkg::POS_W-1:0]    rsp_bit_position
);
   import egbr_pkg::*;

   // busy after every accepted transaction
   `EGBR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `EGBR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_value) && $stable(rsp_status) && $stable(rsp_bit_position))
   `EGBR_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, rsp_status == STATUS_OK || rsp_status == STATUS_NO_DATA || rsp_status == STATUS_PREFIX_LONG)
   `EGBR_ASSERT_NOW(a_long_prefix_zero, clock, reset, rsp_valid && (rsp_status == STATUS_PREFIX_LONG), rsp_result_value == '0)
   `EGBR_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_valid)
endmodule

bind bitstream_exp_golomb_reader_unit egbr_checker u_egbr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_result_value (rsp_if.result_value),
   .rsp_status       (rsp_if.status),
   .rsp_bit_position (rsp_if.bit_position)
);

FILE: tb/sv/bitstream_exp_golomb_reader_unit_tb.sv
// self-checking testbench for the exp-golomb bitstream reader with a directed table and random phases
module bitstream_exp_golomb_reader_unit_tb;
   import egbr_pkg::*;

   localparam int BUF_BYTES      = DEFAULT_BUFFER_BYTES;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 1000;
   localparam int PLAN_ROWS      = 30;

   typedef struct packed {
      logic [RESULT_W-1:0] value;
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    pos;
   } rsp_t;

   typedef enum logic [1:0] {
      ROW_LENGTH,
      ROW_FIXED,
      ROW_PREDICTED
   } row_kind_t;

   typedef struct packed {
      row_kind_t           kind;
      cmd_type             cmd;
      logic [COUNT_W-1:0]  count;
      logic [WVAL_W-1:0]   wval;
      logic [ADDR_W-1:0]   addr;
      logic [DATA_W-1:0]   data;
      rsp_t                want;
   } row_t;

   logic             clock;
   logic             reset;
   logic             csr_write_enable;
   logic [POS_W-1:0] csr_write_data;

   egbr_req_if req_bus ();
   egbr_rsp_if rsp_bus ();

   bitstream_exp_golomb_reader_unit #(
      .BUFFER_BYTES(BUF_BYTES)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_if          (req_bus),
      .rsp_if          (rsp_bus)
   );

   logic [7:0] shadow_bytes [BUF_BYTES];
   bit         byte_loaded [BUF_BYTES];
   int         loaded_addrs [$];
   int         shadow_cursor;
   int         shadow_length;
   rsp_t       pending_rsp [$];
   int         error_count;
   int         items_sent;
   bit         calm;

   row_t plan_rows [PLAN_ROWS] = '{
      '{ROW_FIXED, CMD_READ, 7'd8, 32'h0, 12'h0, 8'h0, '{64'h0, STATUS_NO_DATA, 16'd0}},
      '{ROW_FIXED, CMD_UE, 7'd0, 32'h0, 12'h0, 8'h0, '{64'h0, STATUS_NO_DATA, 16'd0}},
      '{ROW_FIXED, CMD_PUT, 7'd8, 32'hFF, 12'h0, 8'h0, '{64'h0, STATUS_NO_DATA, 16'd0}},
      '{ROW_FIXED, CMD_LOAD, 7'd0, 32'h0, 12'hFFF, 8'hFF, '{64'h0, STATUS_OK, 16'd0}},
      '{ROW_FIXED, CMD_FETCH, 7'd0, 32'h0, 12'hFFF, 8'h0, '{64'hFF, STATUS_OK, 16'd0}},
      '{ROW_LENGTH, CMD_LOAD, 7'd0, 32'hFFFF, 12'h0, 8'h0, '{64'h0, STATUS_OK, 16'd0}},
      '{ROW_FIXED, CMD_LOAD, 7'd0, 32'h0, 12'h0, 8'h00, '{64'h0, STATUS_OK, 16'd0}},
      '{ROW_FIXED, CMD_LOAD, 7'd0, 32'h0, 12'h1, 8'h00, '{64'h0, STATUS_OK, 16'd0}},
      '{ROW_FIXED, CMD_LOAD, 7'd0, 32'h0, 12'h2, 8'h00, '{64'h0, STATUS_OK, 16'd0}},
      '{ROW_FIXED, CMD_LOAD, 7'd0, 32'h0, 12'h3, 8'h00, '{64'h0, STATUS_OK, 16'd0}},
      '{ROW_FIXED, CMD_LOAD, 7'd0, 32'h0, 12'h4, 8'h5F, '{64'h0, STATUS_OK, 16'd0}},
      '{ROW_FIXED, CMD_UE, 7'd0, 32'h0, 12'h0, 8'h0, '{64'h0, STATUS_PREFIX_LONG, 16'd33}},
      '{ROW_PREDICTED, CMD_SE, 7'd0, 32'h0, 12'h0, 8'h0, '{64'h0, STATUS_OK, 16'd0}},
      '{ROW_PREDICTED, CMD_UE, 7'd0, 32'h0, 12'h0, 8'h0, '{64'h0, STATUS_OK, 16'd0}},
      '{ROW_FIXED, CMD_REWIND, 7'd0, 32'h0, 12'h0, 8'h0, '{64'h0, STATUS_OK, 16'd0}},
      '{ROW_FIXED, CMD_READ, 7'd0, 32'h0, 12'h0, 8'h0, '{64'h0, STATUS_OK, 16'd0}},
      '{ROW_PREDICTED, CMD_PEEK, 7'd64, 32'h0, 12'h0, 8'h0, '{64'h0, STATUS_OK, 16'd0}},
      '{ROW_PREDICTED, CMD_READ, 7'd127, 32'h0, 12'h0, 8'h0, '{64'h0, STATUS_OK, 16'd0}},
      '{ROW_PREDICTED, CMD_PUT, 7'd32, 32'hFFFFFFFF, 12'h0, 8'h0, '{64'h0, STATUS_OK, 16'd0}},
      '{ROW_PREDICTED, CMD_PUT, 7'd127, 32'h80000001, 12'h0, 8'h0, '{64'h0, STATUS_OK, 16'd0}},
      '{ROW_FIXED, CMD_REWIND, 7'd0, 32'h0, 12'h0, 8'h0, '{64'h0, STATUS_OK, 16'd0}},
      '{ROW_PREDICTED, CMD_READ, 7'd64, 32'h0, 12'h0, 8'h0, '{64'h0, STATUS_OK, 16'd0}},
      '{ROW_PREDICTED, CMD_FETCH, 7'd0, 32'h0, 12'h0, 8'h0, '{64'h0, STATUS_OK, 16'd0}},
      '{ROW_LENGTH, CMD_LOAD, 7'd0, 32'd16, 12'h0, 8'h0, '{64'h0, STATUS_OK, 16'd0}},
      '{ROW_PREDICTED, CMD_READ, 7'd1, 32'h0, 12'h0, 8'h0, '{64'h0, STATUS_OK, 16'd0}},
      '{ROW_PREDICTED, CMD_PUT, 7'd4, 32'hA, 12'h0, 8'h0, '{64'h0, STATUS_OK, 16'd0}},
      '{ROW_FIXED, CMD_REWIND, 7'd0, 32'h0, 12'h0, 8'h0, '{64'h0, STATUS_OK, 16'd0}},
      '{ROW_PREDICTED, CMD_READ, 7'd20, 32'h0, 12'h0, 8'h0, '{64'h0, STATUS_OK, 16'd0}},
      '{ROW_PREDICTED, CMD_PEEK, 7'd3, 32'h0, 12'h0, 8'h0, '{64'h0, STATUS_OK, 16'd0}},
      '{ROW_PREDICTED, CMD_SE, 7'd0, 32'h0, 12'h0, 8'h0, '{64'h0, STATUS_OK, 16'd0}}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int active_limit();
      return (shadow_length < BUF_BYTES * 8) ? shadow_length : BUF_BYTES * 8;
   endfunction

   function automatic logic fetch_bit(int pos);
      int idx = pos >> 3;
      if (idx >= BUF_BYTES) return 1'b0;
      return shadow_bytes[idx][7 - (pos & 7)];
   endfunction

   function automatic logic [63:0] pull_bits(inout int pos, input int n, inout bit fail);
      logic [63:0] acc = '0;
      int lim = active_limit();
      while (n > 0) begin
         if (pos >= lim) begin
            fail = 1'b1;
            return '0;
         end
         n--;
         acc[n] = fetch_bit(pos);
         pos++;
      end
      return acc;
   endfunction

   function automatic logic [31:0] decode_ue_code(inout logic [STATUS_W-1:0] st);
      int          lim = active_limit();
      int          zeros = -1;
      logic        b = 1'b0;
      bit          fail = 1'b0;
      logic [63:0] suffix;
      while (b == 1'b0 && shadow_cursor < lim && zeros < 32) begin
         b = fetch_bit(shadow_cursor);
         shadow_cursor++;
         zeros++;
      end
      if (zeros < 0) begin
         st = STATUS_NO_DATA;
         return '0;
      end
      if (zeros > MAX_UE_ZEROS) begin
         st = STATUS_PREFIX_LONG;
         return '0;
      end
      if (b == 1'b0) st = STATUS_NO_DATA;
      suffix = pull_bits(shadow_cursor, zeros, fail);
      if (fail) st = STATUS_NO_DATA;
      return ((32'd1 << zeros) - 32'd1) + suffix[31:0];
   endfunction

   function automatic rsp_t predict_response(cmd_type cmd, int count, logic [31:0] wval,
                                             int addr, int data);
      rsp_t                r;
      int                  n = count;
      int                  pos;
      int                  lim;
      int                  idx;
      bit                  fail = 1'b0;
      logic [31:0]         v;
      logic [STATUS_W-1:0] st = STATUS_OK;
      r.value = '0;
      case (cmd)
         CMD_LOAD: begin
            if (addr < BUF_BYTES) begin
               if (!byte_loaded[addr]) loaded_addrs.push_back(addr);
               shadow_bytes[addr] = data[7:0];
               byte_loaded[addr] = 1'b1;
            end else begin
               st = STATUS_NO_DATA;
            end
         end
         CMD_FETCH: begin
            if (addr < BUF_BYTES) r.value = {56'd0, shadow_bytes[addr]};
            else st = STATUS_NO_DATA;
         end
         CMD_READ, CMD_PEEK: begin
            pos = shadow_cursor;
            if (n > MAX_READ_BITS) n = MAX_READ_BITS;
            r.value = pull_bits(pos, n, fail);
            if (fail) st = STATUS_NO_DATA;
            if (cmd == CMD_READ) shadow_cursor = pos;
         end
         CMD_UE: r.value = {32'd0, decode_ue_code(st)};
         CMD_SE: begin
            v = decode_ue_code(st);
            if (v == 32'd0) r.value = '0;
            else if (v[0]) r.value = ({32'd0, v} + 64'd1) >> 1;
            else r.value = 64'd0 - {33'd0, v[31:1]};
         end
         CMD_PUT: begin
            lim = active_limit();
            if (n > MAX_PUT_BITS) n = MAX_PUT_BITS;
            while (n > 0) begin
               if (shadow_cursor >= lim) begin
                  st = STATUS_NO_DATA;
                  break;
               end
               n--;
               idx = shadow_cursor >> 3;
               if (idx < BUF_BYTES) shadow_bytes[idx][7 - (shadow_cursor & 7)] = wval[n];
               shadow_cursor++;
            end
         end
         default: shadow_cursor = 0;
      endcase
      shadow_cursor = shadow_cursor & 16'hFFFF;
      r.status = st;
      r.pos = shadow_cursor[POS_W-1:0];
      return r;
   endfunction

   function automatic int pick_count(int maxc);
      int r = $urandom_range(0, 19);
      if (r == 0) return 0;
      if (r == 1) return $urandom_range(maxc + 1, 127);
      return $urandom_range(1, maxc);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   task automatic send_item(cmd_type cmd, int count, logic [31:0] wval, int addr, int data,
                            bit fixed, rsp_t want);
      rsp_t predicted;
      bit   hs;
      predicted = predict_response(cmd, count, wval, addr, data);
      pending_rsp.push_back(fixed ? want : predicted);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.bit_count <= count[COUNT_W-1:0];
      req_bus.write_value <= wval;
      req_bus.byte_address <= addr[ADDR_W-1:0];
      req_bus.byte_data <= data[DATA_W-1:0];
      do begin
         @(negedge clock);
         hs = (req_bus.valid === 1'b1) && (req_bus.ready === 1'b1);
         @(posedge clock);
      end while (!hs);
      items_sent++;
   endtask

   // bytes the command may touch are loaded first so no unwritten byte is ever read
   task automatic run_cmd(cmd_type cmd, int count, logic [31:0] wval, int addr, int data,
                          bit fixed = 1'b0, rsp_t want = '0);
      int lim;
      int last_bit;
      lim = active_limit();
      if (cmd inside {CMD_READ, CMD_PEEK, CMD_UE, CMD_SE, CMD_PUT} && shadow_cursor < lim) begin
         last_bit = ((shadow_cursor + 72 < lim) ? shadow_cursor + 72 : lim) - 1;
         for (int idx = shadow_cursor >> 3; idx <= (last_bit >> 3); idx++) begin
            if (!byte_loaded[idx])
               send_item(CMD_LOAD, $urandom_range(0, 127), $urandom, idx,
                         $urandom_range(0, 255), 1'b0, '0);
         end
      end
      send_item(cmd, count, wval, addr, data, fixed, want);
   endtask

   task automatic write_length(int len);
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= len[POS_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shadow_length = len & 16'hFFFF;
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   end

   always @(negedge clock) begin
      rsp_t want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_bus.result_value, '0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_bus.result_value !== want.value)
               report_mismatch("result_value", rsp_bus.result_value, want.value);
            if (rsp_bus.status !== want.status)
               report_mismatch("status", {62'd0, rsp_bus.status}, {62'd0, want.status});
            if (rsp_bus.bit_position !== want.pos)
               report_mismatch("bit_position", {48'd0, rsp_bus.bit_position}, {48'd0, want.pos});
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(negedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("bitstream_exp_golomb_reader_unit test failed");
      $finish;
   end

   initial begin
      int          target;
      int          phase;
      int          len;
      int          sel;
      int          ops;
      int          pick;
      int          codes;
      int          z;
      int          tail_n;
      logic [63:0] suffix;
      logic [63:0] tail;
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      req_bus.valid <= 1'b0;
      req_bus.command <= CMD_LOAD;
      req_bus.bit_count <= '0;
      req_bus.write_value <= '0;
      req_bus.byte_address <= '0;
      req_bus.byte_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (plan_rows[i]) begin
         if (plan_rows[i].kind == ROW_LENGTH)
            write_length(plan_rows[i].wval[POS_W-1:0]);
         else
            run_cmd(plan_rows[i].cmd, plan_rows[i].count, plan_rows[i].wval,
                    plan_rows[i].addr, plan_rows[i].data,
                    plan_rows[i].kind == ROW_FIXED, plan_rows[i].want);
      end

      target = items_sent + RANDOM_ITEMS;
      phase = 0;
      while (items_sent < target) begin
         case (phase)
            0: len = 16'h8000;
            1: len = 0;
            2: len = 16'hFFFF;
            3: len = 1;
            default: begin
               sel = $urandom_range(0, 9);
               case (sel)
                  0: len = $urandom_range(0, 65535);
                  1: len = $urandom_range(1024, 32768);
                  2: len = (shadow_cursor > 0) ? $urandom_range(0, shadow_cursor - 1) : 0;
                  3: len = $urandom_range(1, 40);
                  default: len = $urandom_range(40, 1024);
               endcase
            end
         endcase
         write_length(len);
         ops = $urandom_range(20, 80);
         repeat (ops) begin
            if (items_sent < target) begin
               calm = (items_sent > target - 150);
               pick = $urandom_range(0, 99);
               if (pick < 30) begin
                  // encode a few exp-golomb codewords, rewind, decode them back
                  run_cmd(CMD_REWIND, $urandom_range(0, 127), $urandom, 0, 0);
                  codes = $urandom_range(1, 6);
                  repeat (codes) begin
                     sel = $urandom_range(0, 99);
                     if (sel < 60) z = $urandom_range(0, 3);
                     else if (sel < 90) z = $urandom_range(4, 15);
                     else if (sel < 97) z = $urandom_range(16, 31);
                     else z = 32;
                     suffix = (z == 32) ? 64'd0 : ({32'd0, $urandom} & ((64'd1 << z) - 64'd1));
                     if (z > 0)
                        run_cmd(CMD_PUT, z, (z >= 32) ? 32'd0 : ($urandom << z),
                                $urandom_range(0, 4095), $urandom_range(0, 255));
                     tail_n = (z == 32) ? 1 : z + 1;
                     tail = ({32'd0, $urandom} << tail_n) | (64'd1 << (tail_n - 1)) | suffix;
                     run_cmd(CMD_PUT, tail_n, tail[31:0], $urandom_range(0, 4095),
                             $urandom_range(0, 255));
                  end
                  run_cmd(CMD_REWIND, 0, $urandom, 0, 0);
                  repeat (codes)
                     run_cmd(($urandom_range(0, 1) == 0) ? CMD_UE : CMD_SE,
                             $urandom_range(0, 127), $urandom, $urandom_range(0, 4095),
                             $urandom_range(0, 255));
               end else if (pick < 37) begin
                  run_cmd(CMD_LOAD, $urandom_range(0, 127), $urandom,
                          $urandom_range(0, 4095), $urandom_range(0, 255));
               end else if (pick < 44) begin
                  if (loaded_addrs.size() == 0)
                     run_cmd(CMD_LOAD, 0, $urandom, $urandom_range(0, 4095),
                             $urandom_range(0, 255));
                  else
                     run_cmd(CMD_FETCH, $urandom_range(0, 127), $urandom,
                             loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)],
                             $urandom_range(0, 255));
               end else if (pick < 58) begin
                  run_cmd(CMD_READ, pick_count(MAX_READ_BITS), $urandom,
                          $urandom_range(0, 4095), $urandom_range(0, 255));
               end else if (pick < 65) begin
                  run_cmd(CMD_PEEK, pick_count(MAX_READ_BITS), $urandom,
                          $urandom_range(0, 4095), $urandom_range(0, 255));
               end else if (pick < 75) begin
                  run_cmd(CMD_UE, $urandom_range(0, 127), $urandom,
                          $urandom_range(0, 4095), $urandom_range(0, 255));
               end else if (pick < 82) begin
                  run_cmd(CMD_SE, $urandom_range(0, 127), $urandom,
                          $urandom_range(0, 4095), $urandom_range(0, 255));
               end else if (pick < 95) begin
                  run_cmd(CMD_PUT, pick_count(MAX_PUT_BITS), $urandom,
                          $urandom_range(0, 4095), $urandom_range(0, 255));
               end else begin
                  run_cmd(CMD_REWIND, $urandom_range(0, 127), $urandom,
                          $urandom_range(0, 4095), $urandom_range(0, 255));
               end
            end
         end
         phase++;
      end

      calm = 1'b1;
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("bitstream_exp_golomb_reader_unit test passed");
      else
         $display("bitstream_exp_golomb_reader_unit test failed");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+design
design/egbr_pkg.sv
design/egbr_if.sv
design/egbr_ram.sv
design/egbr_chunk.sv
design/bitstream_exp_golomb_reader_unit.sv
design/egbr_checker.sv
tb/sv/bitstream_exp_golomb_reader_unit_tb.sv
